/* rtl/rv32x_pkg.sv */
// Package for the RV32I subset execute unit: constants, status codes, types.
// No dependencies.
package rv32x_pkg;
   localparam int unsigned MemWordsDefault = 4096;
   localparam logic [31:0] CodeLimitReset = 32'hFFFF_FFFF;

   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_SWORD  = 7'h23;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_PCREL  = 7'h17;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_XOR = 3'd4;
   localparam logic [2:0] F3_OR  = 3'd6;
   localparam logic [2:0] F3_W   = 3'd2;

   localparam logic [31:0] SYS_PINT  = 32'd1;
   localparam logic [31:0] SYS_EXIT  = 32'd10;
   localparam logic [31:0] SYS_PCHAR = 32'd11;

   localparam logic [3:0] ST_OK      = 4'd0;
   localparam logic [3:0] ST_EBREAK  = 4'd1;
   localparam logic [3:0] ST_PINT    = 4'd2;
   localparam logic [3:0] ST_PCHAR   = 4'd3;
   localparam logic [3:0] ST_EXIT    = 4'd4;
   localparam logic [3:0] ST_ILLEGAL = 4'd5;
   localparam logic [3:0] ST_FUNCT3  = 4'd6;
   localparam logic [3:0] ST_SYSCALL = 4'd7;
   localparam logic [3:0] ST_ADDR    = 4'd8;
   localparam logic [3:0] ST_HALTED  = 4'd9;

   localparam logic [2:0] K_BAD    = 3'd0;
   localparam logic [2:0] K_ALU    = 3'd1;
   localparam logic [2:0] K_LOAD   = 3'd2;
   localparam logic [2:0] K_STORE  = 3'd3;
   localparam logic [2:0] K_JALR   = 3'd4;
   localparam logic [2:0] K_AUIPC  = 3'd5;
   localparam logic [2:0] K_EBREAK = 3'd6;
   localparam logic [2:0] K_ECALL  = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  fault;   // ST_OK, or ST_ILLEGAL / ST_FUNCT3 found at decode
      logic [2:0]  f3;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [31:0] imm;
   } decoded_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] next_pc;
      logic        reg_written;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic [31:0] call_argument;
      logic        past_end;
   } result_type;
endpackage

/* rtl/rv32x_if.sv */
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing.
interface rv32x_if #(parameter type T = logic [31:0]);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/rv32i_subset_execute_unit.sv */
// RV32I subset execute unit: decoupled decode queue and execute back end.
// Results are registered at issue; LW adds a RAM read. Throughput: one word
// per cycle while rsp_ready is high; LW blocks issue until its data is back.
// Synchronous active-high reset; afterwards the data memory is zeroed, no
// word issued. Depends on rv32x_pkg, rv32x_if, rv32x_front, rv32x_back.
module rv32i_subset_execute_unit
   import rv32x_pkg::*;
#(
   parameter int unsigned MEM_WORDS = MemWordsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic [31:0] rsp_call_argument,
   output logic        rsp_past_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_code_limit
);
   rv32x_if #(.T(logic [31:0])) req_if ();
   rv32x_if #(.T(result_type))  rsp_if ();
   decoded_type q_data;
   logic        q_valid, q_pop, clearing;
   logic [31:0] code_limit_ff;

   assign req_if.valid   = req_valid;
   assign req_if.data    = req_instr_word;
   assign req_ready      = req_if.ready;
   assign rsp_valid      = rsp_if.valid;
   assign rsp_if.ready   = rsp_ready;
   assign rsp_status        = rsp_if.data.status;
   assign rsp_next_pc       = rsp_if.data.next_pc;
   assign rsp_reg_written   = rsp_if.data.reg_written;
   assign rsp_dest_index    = rsp_if.data.dest_index;
   assign rsp_dest_value    = rsp_if.data.dest_value;
   assign rsp_call_argument = rsp_if.data.call_argument;
   assign rsp_past_end      = rsp_if.data.past_end;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) code_limit_ff <= CodeLimitReset;
      else if (csr_valid) code_limit_ff <= csr_code_limit;
   end

   rv32x_front u_front (
      .clock (clock), .reset (reset), .req (req_if),
      .q_data (q_data), .q_valid (q_valid), .q_pop (q_pop)
   );

   rv32x_back #(.MEM_WORDS(MEM_WORDS)) u_back (
      .clock (clock), .reset (reset), .q_data (q_data), .q_valid (q_valid),
      .q_pop (q_pop), .code_limit (code_limit_ff), .clearing (clearing),
      .rsp (rsp_if)
   );

   a_no_issue_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop) else $error("issue during memory clear");
   a_halted_pc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_HALTED |-> !rsp_reg_written)
      else $error("write while halted");
   a_x0_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_index == 5'd0 |-> rsp_dest_value == 32'd0)
      else $error("x0 nonzero");
endmodule

/* rtl/rv32x_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module rv32x_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

/* rtl/rv32x_front.sv */
// Front end: accepts instruction words, decodes them into a two-entry queue.
// Depends on rv32x_pkg and rv32x_if.
module rv32x_front
   import rv32x_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rv32x_if.sink       req,
   output decoded_type q_data,
   output logic        q_valid,
   input  logic        q_pop
);
   decoded_type ent_ff [2];
   decoded_type ent_in [2];
   logic [1:0]  cnt_ff, cnt_in;
   decoded_type dec;
   logic [6:0]  op;
   logic [31:0] w;
   logic        push;

   assign w  = req.data;
   assign op = w[6:0];

   always_comb begin
      dec.f3    = w[14:12];
      dec.rd    = w[11:7];
      dec.rs1   = w[19:15];
      dec.rs2   = w[24:20];
      dec.imm   = {{20{w[31]}}, w[31:20]};
      dec.fault = ST_OK;
      dec.kind  = K_BAD;
      case (op)
         OP_IMM: begin
            dec.kind = K_ALU;
            if (w[14:12] != F3_ADD && w[14:12] != F3_XOR && w[14:12] != F3_OR)
               dec.fault = ST_FUNCT3;
         end
         OP_LOAD: begin
            dec.kind = K_LOAD;
            if (w[14:12] != F3_W) dec.fault = ST_FUNCT3;
         end
         OP_SWORD: begin
            dec.kind = K_STORE;
            dec.imm  = {{20{w[31]}}, w[31:25], w[11:7]};
            if (w[14:12] != F3_W) dec.fault = ST_FUNCT3;
         end
         OP_JALR: begin
            dec.kind = K_JALR;
            if (w[14:12] != F3_ADD) dec.fault = ST_FUNCT3;
         end
         OP_PCREL: begin
            dec.kind = K_AUIPC;
            dec.imm  = {w[31:12], 12'd0};
         end
         OP_SYSTEM: dec.kind = (w == EBREAK_WORD) ? K_EBREAK : K_ECALL;
         default:   dec.fault = ST_ILLEGAL;
      endcase
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = ent_ff[0];

   always_comb begin
      ent_in = ent_ff;
      cnt_in = cnt_ff;
      if (q_pop && q_valid) begin
         ent_in[0] = ent_ff[1];
         cnt_in    = cnt_in - 2'd1;
      end
      if (push) begin
         ent_in[cnt_in[0]] = dec;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) cnt_ff <= 2'd0;
      else       cnt_ff <= cnt_in;
   end
endmodule

/* rtl/rv32x_back.sv */
// Back end: register file, pc, data memory access and result register.
// Depends on rv32x_pkg, rv32x_if and rv32x_ram.
module rv32x_back
   import rv32x_pkg::*;
#(
   parameter int unsigned MEM_WORDS = MemWordsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  decoded_type q_data,
   input  logic        q_valid,
   output logic        q_pop,
   input  logic [31:0] code_limit,
   output logic        clearing,
   rv32x_if.source     rsp
);
   localparam int unsigned AW = $clog2(MEM_WORDS);
   localparam logic [32:0] MemBytes = 33'(MEM_WORDS) * 33'd4;

   logic [31:0] rf_ff [32];
   logic [31:0] pc_ff;
   logic        halt_ff;
   logic        ph_ff;      // load read phase: RAM data is being returned
   logic        clr_ff;
   logic [AW-1:0] clr_addr_ff;
   result_type  out_ff;
   logic        ov_ff;
   logic [4:0]  ld_rd_ff;

   logic [31:0] rs1v, rs2v, a0v, a7v, sum, jt, res_val;
   logic [3:0]  st;
   logic [31:0] npc;
   logic        wr, aok, go, do_ld, mem_we;
   logic [AW-1:0] ram_addr;
   logic [31:0] ram_rd;
   result_type  r;

   assign rs1v = (q_data.rs1 == 5'd0) ? 32'd0 : rf_ff[q_data.rs1];
   assign rs2v = (q_data.rs2 == 5'd0) ? 32'd0 : rf_ff[q_data.rs2];
   assign a0v  = rf_ff[10];
   assign a7v  = rf_ff[17];
   assign sum  = rs1v + q_data.imm;
   assign jt   = {sum[31:1], 1'b0};
   assign aok  = (sum[1:0] == 2'b00) && ({1'b0, sum} < MemBytes);
   assign clearing = clr_ff;

   // item may issue when output slot free (or being drained), no load pending and no memory clear
   assign go = q_valid && !clr_ff && !ph_ff && (!ov_ff || rsp.ready);

   always_comb begin
      st      = ST_OK;
      npc     = pc_ff + 32'd4;
      wr      = 1'b0;
      res_val = 32'd0;
      r.call_argument = 32'd0;
      do_ld   = 1'b0;
      mem_we  = 1'b0;
      if (halt_ff || pc_ff >= code_limit) begin
         st  = ST_HALTED;
         npc = pc_ff;
      end else if (q_data.fault != ST_OK) begin
         st = q_data.fault;
      end else begin
         case (q_data.kind)
            K_ALU: begin
               wr = 1'b1;
               case (q_data.f3)
                  F3_XOR:  res_val = rs1v ^ q_data.imm;
                  F3_OR:   res_val = rs1v | q_data.imm;
                  default: res_val = sum;
               endcase
            end
            K_LOAD: begin
               if (!aok) st = ST_ADDR;
               else begin
                  wr    = 1'b1;
                  do_ld = 1'b1;
               end
            end
            K_STORE: begin
               if (!aok) st = ST_ADDR;
               else mem_we = 1'b1;
            end
            K_JALR: begin
               if (jt[1]) st = ST_ADDR;
               else begin
                  wr      = 1'b1;
                  res_val = pc_ff + 32'd4;
                  npc     = jt;
               end
            end
            K_AUIPC: begin
               wr      = 1'b1;
               res_val = pc_ff + q_data.imm;
            end
            K_EBREAK: st = ST_EBREAK;
            K_ECALL: begin
               if (a7v == SYS_PINT)       st = ST_PINT;
               else if (a7v == SYS_EXIT)  st = ST_EXIT;
               else if (a7v == SYS_PCHAR) st = ST_PCHAR;
               else                       st = ST_SYSCALL;
               if (st != ST_SYSCALL) r.call_argument = a0v;
            end
            default: st = ST_ILLEGAL;
         endcase
      end
      if (st >= ST_ILLEGAL && st <= ST_ADDR) npc = pc_ff;
      if (q_data.rd == 5'd0) res_val = 32'd0;
      r.status      = st;
      r.next_pc     = npc;
      r.reg_written = wr;
      r.dest_index  = wr ? q_data.rd : 5'd0;
      r.dest_value  = wr ? res_val : 32'd0;
      r.past_end    = (npc >= code_limit);
   end

   assign ram_addr = clr_ff ? clr_addr_ff : sum[AW+1:2];

   rv32x_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
      .clock   (clock),
      .wr_en   (clr_ff || (go && mem_we)),
      .addr    (ram_addr),
      .wr_data (clr_ff ? 32'd0 : rs2v),
      .rd_data (ram_rd)
   );

   assign q_pop     = go;
   assign rsp.valid = ov_ff && !ph_ff;
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (go) out_ff <= r;
      if (go) ld_rd_ff <= q_data.rd;
      if (ph_ff) out_ff.dest_value <= (ld_rd_ff == 5'd0) ? 32'd0 : ram_rd;
      if (reset) begin
         for (int i = 0; i < 32; i++) rf_ff[i] <= (i == 2) ? MemBytes[31:0] : 32'd0;
         pc_ff       <= 32'd0;
         halt_ff     <= 1'b0;
         ph_ff       <= 1'b0;
         ov_ff       <= 1'b0;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         if (go && wr && q_data.rd != 5'd0 && !do_ld) rf_ff[q_data.rd] <= res_val;
         if (ph_ff && ld_rd_ff != 5'd0) rf_ff[ld_rd_ff] <= ram_rd;
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(MEM_WORDS - 1)) clr_ff <= 1'b0;
         end
         ph_ff <= go && do_ld;
         if (go) begin
            ov_ff <= 1'b1;
            pc_ff <= npc;
            if ((st >= ST_ILLEGAL && st <= ST_ADDR) || st == ST_EXIT) halt_ff <= 1'b1;
         end else if (rsp.ready && rsp.valid) begin
            ov_ff <= 1'b0;
         end
      end
   end
endmodule
